@@ rtl/scde_pkg.sv @@
package scde_pkg;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SHA512SU0,
    OP_SHA512SU1,
    OP_SHA512H,
    OP_SHA512H2,
    OP_EOR3,
    OP_BCAX,
    OP_RAX1,
    OP_XAR,
    OP_DOT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       elem;
    logic       q;
    logic       u;
    logic [1:0] idx;
    logic [5:0] rot;
  } dec_t;

  localparam logic [31:0] MASK_SU0  = 32'hfffffc00;
  localparam logic [31:0] MATCH_SU0 = 32'hcec08000;
  localparam logic [31:0] MASK_3R   = 32'hffe0fc00;
  localparam logic [31:0] MATCH_SU1 = 32'hce608800;
  localparam logic [31:0] MATCH_H   = 32'hce608000;
  localparam logic [31:0] MATCH_H2  = 32'hce608400;
  localparam logic [31:0] MATCH_RAX = 32'hce608c00;
  localparam logic [31:0] MASK_4R   = 32'hffe08000;
  localparam logic [31:0] MATCH_EOR = 32'hce000000;
  localparam logic [31:0] MATCH_BCX = 32'hce200000;
  localparam logic [31:0] MASK_XAR  = 32'hffe00000;
  localparam logic [31:0] MATCH_XAR = 32'hce800000;
  localparam logic [31:0] MASK_DOTV = 32'h9fe0fc00;
  localparam logic [31:0] MATCH_DOTV = 32'h0e809400;
  localparam logic [31:0] MASK_DOTE = 32'h9fc0f400;
  localparam logic [31:0] MATCH_DOTE = 32'h0f80e000;

  function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] amt);
    logic [6:0] inv;
    inv = 7'd64 - {1'b0, amt};
    return (v >> amt) | (v << inv);
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] a);
    return rotr64(a, 6'd28) ^ rotr64(a, 6'd34) ^ rotr64(a, 6'd39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] a);
    return rotr64(a, 6'd14) ^ rotr64(a, 6'd18) ^ rotr64(a, 6'd41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] a);
    return rotr64(a, 6'd1) ^ rotr64(a, 6'd8) ^ (a >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] a);
    return rotr64(a, 6'd19) ^ rotr64(a, 6'd61) ^ (a >> 6);
  endfunction

  function automatic dec_t decode(input logic [31:0] w);
    dec_t d;
    d.elem = 1'b0;
    d.q    = w[30];
    d.u    = w[29];
    d.idx  = {w[11], w[21]};
    d.rot  = w[15:10];
    if ((w & MASK_SU0) == MATCH_SU0) begin
      d.op = OP_SHA512SU0;
    end else if ((w & MASK_3R) == MATCH_SU1) begin
      d.op = OP_SHA512SU1;
    end else if ((w & MASK_3R) == MATCH_H) begin
      d.op = OP_SHA512H;
    end else if ((w & MASK_3R) == MATCH_H2) begin
      d.op = OP_SHA512H2;
    end else if ((w & MASK_4R) == MATCH_EOR) begin
      d.op = OP_EOR3;
    end else if ((w & MASK_4R) == MATCH_BCX) begin
      d.op = OP_BCAX;
    end else if ((w & MASK_3R) == MATCH_RAX) begin
      d.op = OP_RAX1;
    end else if ((w & MASK_XAR) == MATCH_XAR) begin
      d.op = OP_XAR;
    end else if ((w & MASK_DOTV) == MATCH_DOTV) begin
      d.op = OP_DOT;
    end else if ((w & MASK_DOTE) == MATCH_DOTE) begin
      d.op   = OP_DOT;
      d.elem = 1'b1;
    end else begin
      d.op = OP_NONE;
    end
    return d;
  endfunction

endpackage

@@ rtl/scde_dot.sv @@
module scde_dot
  import scde_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  logic         u,
  input  logic         elem,
  input  logic [1:0]   idx,
  input  logic [127:0] n,
  input  logic [127:0] m,
  input  logic [127:0] d,
  output logic [127:0] acc
);

  logic signed [17:0] prod [16];
  logic signed [17:0] prod_next [16];
  logic [127:0]       d1;
  logic signed [19:0] lane_sum [4];
  logic signed [19:0] lane_sum_next [4];
  logic [127:0]       d2;

  always_comb begin
    logic [3:0]         kb;
    logic [7:0]         bn;
    logic [7:0]         bm;
    logic signed [8:0]  pn;
    logic signed [8:0]  pm;
    for (int k = 0; k < 16; k++) begin
      kb = elem ? {idx, k[1:0]} : k[3:0];
      bn = n[8*k +: 8];
      bm = m[8*kb +: 8];
      pn = u ? $signed({1'b0, bn}) : $signed({bn[7], bn});
      pm = u ? $signed({1'b0, bm}) : $signed({bm[7], bm});
      prod_next[k] = pn * pm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      d1   <= d;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_sum_next[i] = 20'(prod[4*i]) + 20'(prod[4*i+1])
                       + 20'(prod[4*i+2]) + 20'(prod[4*i+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_sum <= lane_sum_next;
      d2       <= d1;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[32*i +: 32] = d2[32*i +: 32] + {{12{lane_sum[i][19]}}, lane_sum[i]};
    end
  end

endmodule

@@ rtl/simd_crypto_dot_execute_unit_core.sv @@
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | instruction, first_*, second_*, third_*, dest_old_*
// output  | out_valid / out_ready| result_lo, result_hi, recognized
//
// Three register stages (s1, s2, output); an accepted instruction passes s1 and s2,
// then the output register, where out_valid rises and the result can transfer out.
// One instruction per cycle is accepted while the output side keeps up.
// The whole pipeline holds when the output register is full and not taken.
// Synchronous reset clears the stage valid bits only.
module simd_crypto_dot_execute_unit_core
  import scde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  input  logic [63:0] first_lo,
  input  logic [63:0] first_hi,
  input  logic [63:0] second_lo,
  input  logic [63:0] second_hi,
  input  logic [63:0] third_lo,
  input  logic [63:0] third_hi,
  input  logic [63:0] dest_old_lo,
  input  logic [63:0] dest_old_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_lo,
  output logic [63:0] result_hi,
  output logic        recognized
);

  logic        advance;
  dec_t        dec;

  logic        s1_valid;
  op_t         s1_op;
  logic        s1_q;
  logic [63:0] s1_lo, s1_hi, s1_m0, s1_m1, s1_n0, s1_d0;
  logic [63:0] s1_lo_next, s1_hi_next;

  logic        s2_valid;
  op_t         s2_op;
  logic        s2_q;
  logic [63:0] s2_lo, s2_hi, s2_t, s2_m1, s2_n0, s2_d0;
  logic [63:0] s2_lo_next;

  logic [127:0] dot_acc;
  logic [63:0]  res_lo_next, res_hi_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign dec      = decode(instruction);

  always_comb begin
    s1_lo_next = dest_old_lo;
    s1_hi_next = dest_old_hi;
    case (dec.op)
      OP_SHA512SU0: begin
        s1_lo_next = dest_old_lo + small_sigma0(dest_old_hi);
        s1_hi_next = dest_old_hi + small_sigma0(first_lo);
      end
      OP_SHA512SU1: begin
        s1_lo_next = dest_old_lo + small_sigma1(first_lo) + second_lo;
        s1_hi_next = dest_old_hi + small_sigma1(first_hi) + second_hi;
      end
      OP_SHA512H: begin
        s1_hi_next = ((second_hi & first_lo) ^ (~second_hi & first_hi))
                   + big_sigma1(second_hi) + dest_old_hi;
      end
      OP_SHA512H2: begin
        s1_hi_next = ((first_lo & second_hi) ^ (first_lo & second_lo)
                   ^ (second_hi & second_lo)) + big_sigma0(second_lo) + dest_old_hi;
      end
      OP_EOR3: begin
        s1_lo_next = first_lo ^ second_lo ^ third_lo;
        s1_hi_next = first_hi ^ second_hi ^ third_hi;
      end
      OP_BCAX: begin
        s1_lo_next = first_lo ^ (second_lo & ~third_lo);
        s1_hi_next = first_hi ^ (second_hi & ~third_hi);
      end
      OP_RAX1: begin
        s1_lo_next = first_lo ^ rotr64(second_lo, 6'd63);
        s1_hi_next = first_hi ^ rotr64(second_hi, 6'd63);
      end
      OP_XAR: begin
        s1_lo_next = rotr64(first_lo ^ second_lo, dec.rot);
        s1_hi_next = rotr64(first_hi ^ second_hi, dec.rot);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op <= dec.op;
      s1_q  <= dec.q;
      s1_lo <= s1_lo_next;
      s1_hi <= s1_hi_next;
      s1_m0 <= second_lo;
      s1_m1 <= second_hi;
      s1_n0 <= first_lo;
      s1_d0 <= dest_old_lo;
    end
  end

  scde_dot u_dot (
    .clk  (clk),
    .en   (advance),
    .u    (dec.u),
    .elem (dec.elem),
    .idx  (dec.idx),
    .n    ({first_hi, first_lo}),
    .m    ({second_hi, second_lo}),
    .d    ({dest_old_hi, dest_old_lo}),
    .acc  (dot_acc)
  );

  always_comb begin
    if (s1_op == OP_SHA512H2) begin
      s2_lo_next = ((s1_hi & s1_m0) ^ (s1_hi & s1_m1) ^ (s1_m1 & s1_m0))
                 + big_sigma0(s1_hi) + s1_d0;
    end else begin
      s2_lo_next = s1_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op <= s1_op;
      s2_q  <= s1_q;
      s2_lo <= s2_lo_next;
      s2_hi <= s1_hi;
      s2_t  <= s1_hi + s1_m0;
      s2_m1 <= s1_m1;
      s2_n0 <= s1_n0;
      s2_d0 <= s1_d0;
    end
  end

  always_comb begin
    res_lo_next = s2_lo;
    res_hi_next = s2_hi;
    case (s2_op)
      OP_SHA512H: begin
        res_lo_next = ((s2_t & s2_m1) ^ (~s2_t & s2_n0)) + big_sigma1(s2_t) + s2_d0;
      end
      OP_DOT: begin
        res_lo_next = dot_acc[63:0];
        res_hi_next = s2_q ? dot_acc[127:64] : 64'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_lo  <= res_lo_next;
      result_hi  <= res_hi_next;
      recognized <= (s2_op != OP_NONE);
    end
  end

endmodule
